// ===== rtl/cartridge_bank_mapper_irq_counter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cartridge bank mapper
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_COUNTER_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_COUNTER_ASSERT_SVH
`ifndef SYNTHESIS
`define CBMIC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CBMIC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CBMIC_ASSERT(label, prop, msg)
`define CBMIC_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== rtl/cbmic_pkg.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Request kinds, register addresses, configuration indexes and widths.
// ----------------------------------------------------------------------------
package cbmic_pkg;

  localparam int FUNC_W      = 2;
  localparam int ADDR_W      = 16;
  localparam int DATA_W      = 8;
  localparam int OFFSET_W    = 21;
  localparam int CFG_INDEX_W = 2;
  localparam int COUNT_W     = 17;
  localparam int RELOAD_W    = 16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_TICK    = 2'd1,
    FUNC_CPU_MAP = 2'd2,
    FUNC_PPU_MAP = 2'd3
  } func_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_PRG_MASK   = 2'd0,
    CFG_CHR_MASK   = 2'd1,
    CFG_CHR_IS_ROM = 2'd2
  } cfg_index_t;

  localparam logic [ADDR_W-1:0] ADDR_PRG0       = 16'h8000;
  localparam logic [ADDR_W-1:0] ADDR_PRG1       = 16'hA000;
  localparam logic [ADDR_W-1:0] ADDR_PRG2       = 16'hC000;
  localparam logic [ADDR_W-1:0] ADDR_MIRROR     = 16'h9001;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_ENABLE = 16'h9003;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_RELOAD = 16'h9004;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_HIGH   = 16'h9005;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_LOW    = 16'h9006;
  localparam logic [ADDR_W-1:0] ADDR_CHR_FIRST  = 16'hB000;
  localparam logic [ADDR_W-1:0] ADDR_CHR_LAST   = 16'hB007;

  localparam logic [DATA_W-1:0] PRG_MASK_RESET = 8'd15;
  localparam logic [DATA_W-1:0] CHR_MASK_RESET = 8'd255;
  localparam logic [DATA_W-1:0] PRG_BANK0_RESET = 8'h00;
  localparam logic [DATA_W-1:0] PRG_BANK1_RESET = 8'h01;
  localparam logic [DATA_W-1:0] PRG_BANK2_RESET = 8'hFE;

  localparam logic [COUNT_W-1:0] COUNT_PARKED = '1;

endpackage

// ===== rtl/cartridge_bank_mapper_irq_counter.sv =====
// ----------------------------------------------------------------------------
// Cartridge bank mapper with interrupt counter
// Register writes, counter ticks and CPU/PPU address translation in one pipe.
// ----------------------------------------------------------------------------
// Each request on the input channel (valid/ready) is one of a register write,
// a CPU clock tick, a CPU address translation or a PPU address translation.
// Every request yields exactly one result on the output channel: the interrupt
// line and mirroring after the request, and for translations the byte offset,
// a hit flag and a ROM flag.
// A request is held in an input register, where the decode, bank select and
// counter update are done, and the result is then registered in the result
// register. One request is accepted in every cycle while the result register
// drains.
// When the receiver stalls, the result register holds its value and the input
// register holds the next request; in_ready falls once both are full.
// Reset restores the bank registers, clears the counter and the interrupt,
// empties both pipeline registers and loads the configuration defaults. The
// configuration port writes a register at any edge with cfg_we high, rst low.
// ----------------------------------------------------------------------------
`include "cartridge_bank_mapper_irq_counter_assert.svh"

module cartridge_bank_mapper_irq_counter #(
  parameter int PRG_BANK_BITS = 8,
  parameter int CHR_BANK_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [cbmic_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [cbmic_pkg::DATA_W-1:0]      cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [cbmic_pkg::FUNC_W-1:0]      func,
  input  logic [cbmic_pkg::ADDR_W-1:0]      bus_address,
  input  logic [cbmic_pkg::DATA_W-1:0]      write_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              irq_line,
  output logic                              mirror_horizontal,
  output logic [cbmic_pkg::OFFSET_W-1:0]    mapped_offset,
  output logic                              mapped_valid,
  output logic                              mapped_rom
);

  import cbmic_pkg::*;

  logic [PRG_BANK_BITS-1:0] prg_bank_mask;
  logic [CHR_BANK_BITS-1:0] chr_bank_mask;
  logic                     chr_is_rom;

  logic [PRG_BANK_BITS-1:0] prg_banks [3];
  logic [PRG_BANK_BITS-1:0] prg_banks_next [3];
  logic [CHR_BANK_BITS-1:0] chr_banks [8];
  logic [CHR_BANK_BITS-1:0] chr_banks_next [8];
  logic                     mirroring;
  logic                     mirroring_next;
  logic                     irq_enabled;
  logic                     irq_enabled_next;
  logic [RELOAD_W-1:0]      irq_reload_value;
  logic [RELOAD_W-1:0]      irq_reload_value_next;
  logic [COUNT_W-1:0]       irq_count;
  logic [COUNT_W-1:0]       irq_count_next;
  logic                     irq_pending;
  logic                     irq_pending_next;

  logic              s1_valid;
  func_t             s1_func;
  logic [ADDR_W-1:0] s1_addr;
  logic [DATA_W-1:0] s1_data;
  logic              s1_fire;

  logic [OFFSET_W-1:0]      offset_next;
  logic                     valid_next;
  logic                     rom_next;
  logic [PRG_BANK_BITS-1:0] prg_bank_sel;
  logic [CHR_BANK_BITS-1:0] chr_bank_sel;
  logic                     reload_hit;
  logic                     tick_hit;

  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_bank_mask <= PRG_MASK_RESET[PRG_BANK_BITS-1:0];
      chr_bank_mask <= CHR_MASK_RESET[CHR_BANK_BITS-1:0];
      chr_is_rom    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_PRG_MASK:   prg_bank_mask <= cfg_wdata[PRG_BANK_BITS-1:0];
        CFG_CHR_MASK:   chr_bank_mask <= cfg_wdata[CHR_BANK_BITS-1:0];
        CFG_CHR_IS_ROM: chr_is_rom    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_func <= func_t'(func);
      s1_addr <= bus_address;
      s1_data <= write_data;
    end
  end

  assign reload_hit = s1_fire && (s1_func == FUNC_WRITE) && (s1_addr == ADDR_IRQ_RELOAD);
  assign tick_hit   = s1_fire && (s1_func == FUNC_TICK);

  always_comb begin
    prg_banks_next        = prg_banks;
    chr_banks_next        = chr_banks;
    mirroring_next        = mirroring;
    irq_enabled_next      = irq_enabled;
    irq_reload_value_next = irq_reload_value;
    irq_count_next        = irq_count;
    irq_pending_next      = irq_pending;
    offset_next           = '0;
    valid_next            = 1'b0;
    rom_next              = 1'b0;
    prg_bank_sel          = '0;
    chr_bank_sel          = '0;

    case (s1_addr[14:13])
      2'd0:    prg_bank_sel = prg_banks[0] & prg_bank_mask;
      2'd1:    prg_bank_sel = prg_banks[1] & prg_bank_mask;
      2'd2:    prg_bank_sel = prg_banks[2] & prg_bank_mask;
      default: prg_bank_sel = prg_bank_mask;
    endcase
    chr_bank_sel = chr_banks[s1_addr[12:10]] & chr_bank_mask;

    if (s1_fire) begin
      case (s1_func)
        FUNC_WRITE: begin
          case (s1_addr) inside
            [ADDR_CHR_FIRST:ADDR_CHR_LAST]:
              chr_banks_next[s1_addr[2:0]] = s1_data[CHR_BANK_BITS-1:0];
            ADDR_PRG0: prg_banks_next[0] = s1_data[PRG_BANK_BITS-1:0];
            ADDR_PRG1: prg_banks_next[1] = s1_data[PRG_BANK_BITS-1:0];
            ADDR_PRG2: prg_banks_next[2] = s1_data[PRG_BANK_BITS-1:0];
            ADDR_MIRROR: mirroring_next = s1_data[7];
            ADDR_IRQ_ENABLE: begin
              irq_enabled_next = s1_data[7];
              irq_pending_next = 1'b0;
            end
            ADDR_IRQ_RELOAD: begin
              irq_count_next   = {1'b0, irq_reload_value};
              irq_pending_next = 1'b0;
            end
            ADDR_IRQ_HIGH: irq_reload_value_next = {s1_data, irq_reload_value[7:0]};
            ADDR_IRQ_LOW:  irq_reload_value_next = {irq_reload_value[15:8], s1_data};
            default: ;
          endcase
        end
        FUNC_TICK: begin
          if (irq_enabled) begin
            if (irq_count == '0) begin
              irq_count_next   = COUNT_PARKED;
              irq_pending_next = 1'b1;
            end else if (!irq_count[COUNT_W-1]) begin
              irq_count_next = irq_count - COUNT_W'(1);
            end
          end
        end
        FUNC_CPU_MAP: begin
          if (s1_addr[15]) begin
            offset_next = OFFSET_W'({prg_bank_sel, s1_addr[12:0]});
            valid_next  = 1'b1;
            rom_next    = 1'b1;
          end
        end
        FUNC_PPU_MAP: begin
          if (s1_addr[15:13] == 3'd0) begin
            offset_next = OFFSET_W'({chr_bank_sel, s1_addr[9:0]});
            valid_next  = 1'b1;
            rom_next    = chr_is_rom;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_banks[0]     <= PRG_BANK0_RESET[PRG_BANK_BITS-1:0];
      prg_banks[1]     <= PRG_BANK1_RESET[PRG_BANK_BITS-1:0];
      prg_banks[2]     <= PRG_BANK2_RESET[PRG_BANK_BITS-1:0];
      chr_banks        <= '{default: '0};
      mirroring        <= 1'b0;
      irq_enabled      <= 1'b0;
      irq_reload_value <= '0;
      irq_count        <= '0;
      irq_pending      <= 1'b0;
    end else begin
      prg_banks        <= prg_banks_next;
      chr_banks        <= chr_banks_next;
      mirroring        <= mirroring_next;
      irq_enabled      <= irq_enabled_next;
      irq_reload_value <= irq_reload_value_next;
      irq_count        <= irq_count_next;
      irq_pending      <= irq_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      irq_line          <= irq_pending_next;
      mirror_horizontal <= mirroring_next;
      mapped_offset     <= offset_next;
      mapped_valid      <= valid_next;
      mapped_rom        <= rom_next;
    end
  end

  `CBMIC_ASSERT(a_parked_holds,
    (irq_count == COUNT_PARKED && !reload_hit) |=> irq_count == COUNT_PARKED,
    "Parked counter left its park value without a reload.")
  `CBMIC_ASSERT(a_irq_rises_on_tick,
    (!irq_pending && !tick_hit) |=> !irq_pending,
    "Interrupt raised by something other than a counter tick.")
  `CBMIC_ASSERT(a_reload_loads,
    reload_hit |=> irq_count == {1'b0, $past(irq_reload_value)},
    "Reload write did not load the counter.")
  `CBMIC_ASSERT(a_stall_full,
    !in_ready |-> (s1_valid && out_valid && !out_ready),
    "Input stalled while the pipeline had room.")
  `CBMIC_ASSERT(a_rom_needs_hit,
    (out_valid && mapped_rom) |-> mapped_valid,
    "ROM flag set on a result without a mapped hit.")

endmodule

// ===== bench/tb_cartridge_bank_mapper_irq_counter.sv =====
// ----------------------------------------------------------------------------
// Testbench for the cartridge bank mapper with interrupt counter
// A table of directed requests runs first, followed by random phases.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the bank registers, the interrupt timer and
// the configuration. It also predicts the result of every accepted request.
// Each result that leaves the block is compared field by field with the
// oldest expected result. The random phases mix stray requests with timer
// programming sequences and vary the idling on both channels. During one long
// hold-off of the receiver, the block fills up and must stall its input.
// ----------------------------------------------------------------------------
module tb_cartridge_bank_mapper_irq_counter;
  import cbmic_pkg::*;

  localparam int PRG_BITS    = 8;
  localparam int CHR_BITS    = 8;
  localparam int PHASE_ITEMS = 470;
  localparam int HOLD_CYCLES = 300;
  localparam logic [7:0] PRG_BITS_MASK = 8'((1 << PRG_BITS) - 1);
  localparam logic [7:0] CHR_BITS_MASK = 8'((1 << CHR_BITS) - 1);
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic                irq;
    logic                mirror;
    logic [OFFSET_W-1:0] offset;
    logic                hit;
    logic                rom;
  } map_result_t;

  typedef struct packed {
    func_t       f;
    logic [15:0] a;
    logic [7:0]  d;
    logic        known;
    map_result_t want;
  } step_t;

  localparam map_result_t MISS = '0;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]      cfg_wdata = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [FUNC_W-1:0]      func = FUNC_WRITE;
  logic [ADDR_W-1:0]      bus_address = '0;
  logic [DATA_W-1:0]      write_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   irq_line;
  logic                   mirror_horizontal;
  logic [OFFSET_W-1:0]    mapped_offset;
  logic                   mapped_valid;
  logic                   mapped_rom;

  cartridge_bank_mapper_irq_counter #(
    .PRG_BANK_BITS(PRG_BITS),
    .CHR_BANK_BITS(CHR_BITS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .func(func),
    .bus_address(bus_address),
    .write_data(write_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .irq_line(irq_line),
    .mirror_horizontal(mirror_horizontal),
    .mapped_offset(mapped_offset),
    .mapped_valid(mapped_valid),
    .mapped_rom(mapped_rom)
  );

  always #2 clk = ~clk;

  // Predicted mapper state and configuration.
  logic [7:0]         prg_bank [3];
  logic [7:0]         chr_bank [8];
  logic               mirror;
  logic               irq_en;
  logic               irq_pend;
  logic [15:0]        reload;
  logic [COUNT_W-1:0] irq_count;
  logic [7:0]         prg_mask;
  logic [7:0]         chr_mask;
  logic               chr_rom;

  map_result_t pending_results [$];
  int          mismatch_count = 0;
  int          result_count = 0;
  int          send_idle = 0;
  int          recv_stall = 0;
  bit          hold_ask = 1'b0;
  int          hold_left = 0;

  logic [15:0] reg_addrs [9] = '{ADDR_PRG0, ADDR_PRG1, ADDR_PRG2, ADDR_MIRROR,
                                 ADDR_IRQ_ENABLE, ADDR_IRQ_RELOAD, ADDR_IRQ_HIGH,
                                 ADDR_IRQ_LOW, ADDR_CHR_FIRST};

  step_t steps [26] = '{
    '{FUNC_CPU_MAP, 16'h8000, 8'h00, 1'b1, '{1'b0, 1'b0, 21'h00000, 1'b1, 1'b1}},
    '{FUNC_CPU_MAP, 16'hFFFF, 8'h00, 1'b1, '{1'b0, 1'b0, 21'h1FFFF, 1'b1, 1'b1}},
    '{FUNC_CPU_MAP, 16'h7FFF, 8'hFF, 1'b1, MISS},
    '{FUNC_CPU_MAP, 16'hC000, 8'h00, 1'b1, '{1'b0, 1'b0, 21'h1C000, 1'b1, 1'b1}},
    '{FUNC_PPU_MAP, 16'h0000, 8'h00, 1'b1, '{1'b0, 1'b0, 21'h00000, 1'b1, 1'b1}},
    '{FUNC_PPU_MAP, 16'h2000, 8'h00, 1'b1, MISS},
    '{FUNC_PPU_MAP, 16'hFFFF, 8'h00, 1'b1, MISS},
    '{FUNC_TICK,    16'h0000, 8'h00, 1'b1, MISS},
    '{FUNC_WRITE,   ADDR_MIRROR,     8'h80, 1'b1, '{1'b0, 1'b1, 21'h0, 1'b0, 1'b0}},
    '{FUNC_WRITE,   ADDR_IRQ_LOW,    8'h02, 1'b0, MISS},
    '{FUNC_WRITE,   ADDR_IRQ_HIGH,   8'h00, 1'b0, MISS},
    '{FUNC_WRITE,   ADDR_IRQ_RELOAD, 8'h00, 1'b0, MISS},
    '{FUNC_WRITE,   ADDR_IRQ_ENABLE, 8'h80, 1'b0, MISS},
    '{FUNC_TICK,    16'hFFFF, 8'hFF, 1'b0, MISS},
    '{FUNC_TICK,    16'h0000, 8'h00, 1'b0, MISS},
    '{FUNC_TICK,    16'h0000, 8'h00, 1'b0, MISS},
    '{FUNC_TICK,    16'h0000, 8'h00, 1'b0, MISS},
    '{FUNC_CPU_MAP, 16'hA000, 8'h00, 1'b0, MISS},
    '{FUNC_WRITE,   ADDR_IRQ_ENABLE, 8'h7F, 1'b0, MISS},
    '{FUNC_WRITE,   ADDR_CHR_LAST,   8'hFF, 1'b0, MISS},
    '{FUNC_PPU_MAP, 16'h1FFF, 8'h00, 1'b0, MISS},
    '{FUNC_WRITE,   ADDR_PRG0,       8'hFF, 1'b0, MISS},
    '{FUNC_CPU_MAP, 16'h9FFF, 8'h00, 1'b0, MISS},
    '{FUNC_WRITE,   16'h9002,        8'hFF, 1'b0, MISS},
    '{FUNC_WRITE,   16'hB008,        8'hFF, 1'b0, MISS},
    '{FUNC_WRITE,   ADDR_MIRROR,     8'h7F, 1'b0, MISS}
  };

  task automatic reset_mapper_model();
    prg_bank[0] = PRG_BANK0_RESET;
    prg_bank[1] = PRG_BANK1_RESET;
    prg_bank[2] = PRG_BANK2_RESET;
    foreach (chr_bank[i]) chr_bank[i] = '0;
    mirror    = 1'b0;
    irq_en    = 1'b0;
    irq_pend  = 1'b0;
    reload    = '0;
    irq_count = '0;
    prg_mask  = PRG_MASK_RESET;
    chr_mask  = CHR_MASK_RESET;
    chr_rom   = 1'b1;
  endtask

  function automatic map_result_t predict_mapper(func_t f, logic [15:0] a, logic [7:0] d);
    map_result_t r;
    logic [7:0]  bank;
    r = '0;
    case (f)
      FUNC_WRITE: begin
        if (a >= ADDR_CHR_FIRST && a <= ADDR_CHR_LAST) begin
          chr_bank[a[2:0]] = d;
        end else begin
          case (a)
            ADDR_PRG0:       prg_bank[0] = d;
            ADDR_PRG1:       prg_bank[1] = d;
            ADDR_PRG2:       prg_bank[2] = d;
            ADDR_MIRROR:     mirror = d[7];
            ADDR_IRQ_ENABLE: begin
              irq_en   = d[7];
              irq_pend = 1'b0;
            end
            ADDR_IRQ_RELOAD: begin
              irq_count = {1'b0, reload};
              irq_pend  = 1'b0;
            end
            ADDR_IRQ_HIGH:   reload[15:8] = d;
            ADDR_IRQ_LOW:    reload[7:0] = d;
            default: ;
          endcase
        end
      end
      FUNC_TICK: begin
        if (irq_en) begin
          if (irq_count == '0) begin
            irq_count = COUNT_PARKED;
            irq_pend  = 1'b1;
          end else if (!irq_count[COUNT_W-1]) begin
            irq_count = irq_count - COUNT_W'(1);
          end
        end
      end
      FUNC_CPU_MAP: begin
        if (a[15]) begin
          if (a[14:13] == 2'd3) bank = prg_mask;
          else bank = prg_bank[a[14:13]] & prg_mask;
          bank     = bank & PRG_BITS_MASK;
          r.offset = {bank, a[12:0]};
          r.hit    = 1'b1;
          r.rom    = 1'b1;
        end
      end
      default: begin
        if (a[15:13] == 3'b000) begin
          bank     = chr_bank[a[12:10]] & chr_mask & CHR_BITS_MASK;
          r.offset = {3'b000, bank, a[9:0]};
          r.hit    = 1'b1;
          r.rom    = chr_rom;
        end
      end
    endcase
    r.irq    = irq_pend;
    r.mirror = mirror;
    return r;
  endfunction

  task automatic flag_mismatch(string field, logic [OFFSET_W-1:0] got,
                               logic [OFFSET_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("result %0d: %s is %h, expected %h", result_count, field, got, want);
  endtask

  // Results are sampled with the values from before the edge.
  always @(posedge clk) begin
    map_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", '0, '0);
      end else begin
        want = pending_results.pop_front();
        if (irq_line !== want.irq)
          flag_mismatch("irq_line", OFFSET_W'(irq_line), OFFSET_W'(want.irq));
        if (mirror_horizontal !== want.mirror)
          flag_mismatch("mirror_horizontal", OFFSET_W'(mirror_horizontal),
                        OFFSET_W'(want.mirror));
        if (mapped_offset !== want.offset)
          flag_mismatch("mapped_offset", mapped_offset, want.offset);
        if (mapped_valid !== want.hit)
          flag_mismatch("mapped_valid", OFFSET_W'(mapped_valid), OFFSET_W'(want.hit));
        if (mapped_rom !== want.rom)
          flag_mismatch("mapped_rom", OFFSET_W'(mapped_rom), OFFSET_W'(want.rom));
      end
      result_count++;
    end
  end

  // The receiver keeps its own count of a long hold-off.
  always @(posedge clk) begin
    if (hold_ask) begin
      hold_left = HOLD_CYCLES;
      hold_ask  = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic send_item(func_t f, logic [15:0] a, logic [7:0] d,
                           logic known = 1'b0, map_result_t want = '0);
    map_result_t got;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    bus_address <= a;
    write_data  <= d;
    do @(posedge clk); while (!in_ready);
    got = predict_mapper(f, a, d);
    pending_results.push_back(known ? want : got);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    case (idx)
      CFG_PRG_MASK:   prg_mask = v;
      CFG_CHR_MASK:   chr_mask = v;
      CFG_CHR_IS_ROM: chr_rom = v[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [7:0] pm, logic [7:0] cm, logic [7:0] rom);
    write_reg(CFG_PRG_MASK, pm);
    write_reg(CFG_CHR_MASK, cm);
    write_reg(CFG_UNUSED, 8'($urandom));
    write_reg(CFG_CHR_IS_ROM, rom);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_all_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_stray_request();
    func_t       f;
    logic [15:0] a;
    logic [7:0]  d;
    int          pick;
    int          k;
    f    = func_t'($urandom_range(3));
    a    = 16'($urandom);
    d    = 8'($urandom);
    pick = $urandom_range(99);
    k    = $urandom_range(8);
    case (f)
      FUNC_WRITE: begin
        if (pick < 70) begin
          a = reg_addrs[k];
          if (a == ADDR_CHR_FIRST) a = a + 16'($urandom_range(7));
        end else if (pick < 85) begin
          a = reg_addrs[k] ^ (16'd1 << $urandom_range(15));
        end
      end
      FUNC_CPU_MAP: if (pick < 80) a[15] = 1'b1;
      FUNC_PPU_MAP: if (pick < 80) a[15:13] = 3'b000;
      default: ;
    endcase
    send_item(f, a, d);
  endtask

  // Programmes a short count, mostly starts the timer and ticks it, sometimes past zero.
  task automatic send_timer_sequence(inout int sent);
    logic [7:0] lo;
    int         ticks;
    lo = 8'($urandom_range(12));
    send_item(FUNC_WRITE, ADDR_IRQ_LOW, lo);
    send_item(FUNC_WRITE, ADDR_IRQ_HIGH, ($urandom_range(99) < 85) ? 8'h00 : 8'($urandom));
    send_item(FUNC_WRITE, ADDR_IRQ_RELOAD, 8'($urandom));
    send_item(FUNC_WRITE, ADDR_IRQ_ENABLE, {($urandom_range(9) != 0), 7'($urandom)});
    ticks = $urandom_range(lo + 4);
    repeat (ticks) begin
      if ($urandom_range(4) == 0)
        send_item(func_t'($urandom_range(1) ? FUNC_CPU_MAP : FUNC_PPU_MAP),
                  16'($urandom), 8'($urandom));
      else
        send_item(FUNC_TICK, 16'($urandom), 8'($urandom));
    end
    sent += 4 + ticks;
  endtask

  initial begin
    int sent;
    bit hold_done;
    hold_done = 1'b0;
    reset_mapper_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (steps[i])
      send_item(steps[i].f, steps[i].a, steps[i].d, steps[i].known, steps[i].want);
    in_valid <= 1'b0;
    wait_all_results();

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle  = 0;
          recv_stall = 0;
          set_config(8'hFF, 8'h00, 8'h00);
        end
        1: begin
          send_idle  = 71;
          recv_stall = 0;
          set_config(8'h00, 8'hFF, 8'h01);
        end
        2: begin
          send_idle  = 0;
          recv_stall = 71;
          set_config(8'($urandom), 8'($urandom), 8'($urandom));
        end
        default: begin
          send_idle  = 24;
          recv_stall = 24;
          set_config(8'($urandom), 8'($urandom), 8'($urandom));
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (p == 0 && !hold_done && sent >= 150) begin
          hold_ask  = 1'b1;
          hold_done = 1'b1;
        end
        if ($urandom_range(99) < 30) begin
          send_timer_sequence(sent);
        end else begin
          send_stray_request();
          sent++;
        end
      end
      in_valid <= 1'b0;
      wait_all_results();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("** cartridge_bank_mapper_irq_counter: PASSED **");
    else
      $display("** cartridge_bank_mapper_irq_counter: FAILED **");
    $finish;
  end

  initial begin
    #2000000;
    $display("** cartridge_bank_mapper_irq_counter: FAILED **");
    $finish;
  end

endmodule
